### hw/rtl/scf_pkg.sv
// Shared types and constants for the 3x3 stencil current filter.
// Used by scf_lane, stencil3x3_current_filter_top and its testbench; no dependencies.
`default_nettype none

package scf_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam int WIDTH_BITS  = 11;
   localparam int HEIGHT_BITS = 13;
   localparam int ROW_BITS    = 12;
   localparam int WEIGHT_BITS = 8;
   localparam int RECIP_BITS  = 16;
   localparam int FRAC_BITS   = 16;

   localparam int MIN_DIM    = 3;
   localparam int MAX_HEIGHT = 4096;

   localparam logic [WIDTH_BITS-1:0]         RST_FRAME_WIDTH   = 11'd1024;
   localparam logic [HEIGHT_BITS-1:0]        RST_FRAME_HEIGHT  = 13'd1024;
   localparam logic signed [WEIGHT_BITS-1:0] RST_WEIGHT_MIDDLE = 8'sd20;
   localparam logic signed [WEIGHT_BITS-1:0] RST_WEIGHT_SIDE   = -8'sd1;
   localparam logic signed [WEIGHT_BITS-1:0] RST_WEIGHT_CORNER = -8'sd1;
   localparam logic [RECIP_BITS-1:0]         RST_NORM_RECIP    = 16'd5461;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FRAME_WIDTH   = 3'd0,
      REG_FRAME_HEIGHT  = 3'd1,
      REG_WEIGHT_MIDDLE = 3'd2,
      REG_WEIGHT_SIDE   = 3'd3,
      REG_WEIGHT_CORNER = 3'd4,
      REG_NORM_RECIP    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic shift;
      logic mul;
      logic prod;
   } lane_ctrl_type;

   typedef struct packed {
      logic signed [WEIGHT_BITS-1:0] middle;
      logic signed [WEIGHT_BITS-1:0] side;
      logic signed [WEIGHT_BITS-1:0] corner;
      logic [RECIP_BITS-1:0]         recip;
   } lane_coef_type;

endpackage

`default_nettype wire

### hw/rtl/scf_lane.sv
// One component lane: 3x3 window registers, weighted sum, Q16 scaling and saturation.
// Depends on scf_pkg for the control and coefficient structs.
`default_nettype none

module scf_lane #(
   parameter int SAMPLE_BITS = 24
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire scf_pkg::lane_ctrl_type    ctrl,
   input  wire scf_pkg::lane_coef_type    coef,
   input  wire logic signed [SAMPLE_BITS-1:0] up2,
   input  wire logic signed [SAMPLE_BITS-1:0] up1,
   input  wire logic signed [SAMPLE_BITS-1:0] sample,
   output logic signed [SAMPLE_BITS-1:0]  result
);

   localparam int SUM_BITS   = SAMPLE_BITS + 2;
   localparam int PART_BITS  = SUM_BITS + scf_pkg::WEIGHT_BITS;
   localparam int ACC_BITS   = PART_BITS + 2;
   localparam int PROD_BITS  = ACC_BITS + scf_pkg::RECIP_BITS + 1;
   localparam int SHIFT_BITS = PROD_BITS - scf_pkg::FRAC_BITS;

   logic signed [SAMPLE_BITS-1:0] cell_ff [3][3];
   logic signed [SUM_BITS-1:0]    sides;
   logic signed [SUM_BITS-1:0]    corners;
   logic signed [PART_BITS-1:0]   mid_part_in, side_part_in, corner_part_in;
   logic signed [PART_BITS-1:0]   mid_part_ff, side_part_ff, corner_part_ff;
   logic signed [ACC_BITS-1:0]    acc;
   logic signed [PROD_BITS-1:0]   prod_in;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic signed [SHIFT_BITS-1:0]  shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               cell_ff[r][k] <= '0;
            end
         end
      end else if (ctrl.shift) begin
         for (int r = 0; r < 3; r++) begin
            cell_ff[r][0] <= cell_ff[r][1];
            cell_ff[r][1] <= cell_ff[r][2];
         end
         cell_ff[0][2] <= up2;
         cell_ff[1][2] <= up1;
         cell_ff[2][2] <= sample;
      end
   end

   always_comb begin
      sides   = SUM_BITS'(cell_ff[0][1]) + SUM_BITS'(cell_ff[1][0])
              + SUM_BITS'(cell_ff[1][2]) + SUM_BITS'(cell_ff[2][1]);
      corners = SUM_BITS'(cell_ff[0][0]) + SUM_BITS'(cell_ff[0][2])
              + SUM_BITS'(cell_ff[2][0]) + SUM_BITS'(cell_ff[2][2]);
      mid_part_in    = PART_BITS'(coef.middle) * PART_BITS'(cell_ff[1][1]);
      side_part_in   = PART_BITS'(coef.side) * PART_BITS'(sides);
      corner_part_in = PART_BITS'(coef.corner) * PART_BITS'(corners);
      acc     = ACC_BITS'(mid_part_ff) + ACC_BITS'(side_part_ff) + ACC_BITS'(corner_part_ff);
      prod_in = PROD_BITS'(acc) * PROD_BITS'($signed({1'b0, coef.recip}));
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul) begin
         mid_part_ff    <= mid_part_in;
         side_part_ff   <= side_part_in;
         corner_part_ff <= corner_part_in;
      end
      if (ctrl.prod) begin
         prod_ff <= prod_in;
      end
   end

   // Dropping the fraction bits of a two's complement value rounds toward minus infinity.
   always_comb begin
      shifted = $signed(prod_ff[PROD_BITS-1:scf_pkg::FRAC_BITS]);
      if ((&shifted[SHIFT_BITS-1:SAMPLE_BITS-1]) || !(|shifted[SHIFT_BITS-1:SAMPLE_BITS-1])) begin
         result = shifted[SAMPLE_BITS-1:0];
      end else if (shifted[SHIFT_BITS-1]) begin
         result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

endmodule

`default_nettype wire

### hw/rtl/scf_merge.sv
// Output stage: gathers the three lane results and the frame flag into the response register.
// Depends on nothing beyond the lane results supplied by the top level.
`default_nettype none

module scf_merge #(
   parameter int SAMPLE_BITS = 24
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                load,
   input  wire logic signed [SAMPLE_BITS-1:0] lane_x,
   input  wire logic signed [SAMPLE_BITS-1:0] lane_y,
   input  wire logic signed [SAMPLE_BITS-1:0] lane_z,
   input  wire                                last,
   output logic                               free,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_filtered_x,
   output logic signed [SAMPLE_BITS-1:0]      rsp_filtered_y,
   output logic signed [SAMPLE_BITS-1:0]      rsp_filtered_z,
   output logic                               rsp_last_of_frame
);

   logic                          valid_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff, y_ff, z_ff;
   logic                          last_ff;

   assign free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff    <= lane_x;
         y_ff    <= lane_y;
         z_ff    <= lane_z;
         last_ff <= last;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_filtered_x    = x_ff;
   assign rsp_filtered_y    = y_ff;
   assign rsp_filtered_z    = z_ff;
   assign rsp_last_of_frame = last_ff;

endmodule

`default_nettype wire

### hw/rtl/stencil3x3_current_filter_top.sv
// Stencil filter top level: raster tracking, line store, control sequencer and registers.
// Depends on scf_pkg, scf_lane and scf_merge.
//
// Usage: grid points enter on the req_ channel in raster order, with req_first_of_frame set
// on the first point of each frame. A point at row r >= 2 and column c >= 2 completes the
// 3x3 window centred at (r-1, c-1) and yields one response on the rsp_ channel carrying the
// filtered x, y and z components; rsp_last_of_frame marks the final one of a frame.
// Other points yield nothing. Registers are written on the csr_ channel, which is always
// ready, and must only be changed while no request is in flight.
// Sequence: a point that yields no result passes through a line store read, then write back.
// A point that yields a result passes through line store read, window shift, weighted sum,
// Q16 multiply, then transfer into the output register, which waits while that register is
// full; the result is visible in the cycle after that transfer. The line store read and the
// two multiplier stages set the length of this sequence.
// If the receiver stalls, the finished result waits in the output register while the next
// point is accepted; a further result then waits until the register is emptied.
// Reset clears the raster position, the window and the control state and restores the
// register defaults. The line store is not cleared.
`default_nettype none

module stencil3x3_current_filter_top #(
   parameter int MAX_WIDTH   = 1024,
   parameter int SAMPLE_BITS = 24
) (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        req_valid,
   output logic                                       req_ready,
   input  wire                                        req_first_of_frame,
   input  wire logic signed [SAMPLE_BITS-1:0]         req_sample_x,
   input  wire logic signed [SAMPLE_BITS-1:0]         req_sample_y,
   input  wire logic signed [SAMPLE_BITS-1:0]         req_sample_z,
   output logic                                       rsp_valid,
   input  wire                                        rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]              rsp_filtered_x,
   output logic signed [SAMPLE_BITS-1:0]              rsp_filtered_y,
   output logic signed [SAMPLE_BITS-1:0]              rsp_filtered_z,
   output logic                                       rsp_last_of_frame,
   input  wire                                        csr_valid,
   output logic                                       csr_ready,
   input  wire logic [scf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [scf_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int MW_BITS   = $clog2(MAX_WIDTH + 1);
   localparam int DIM_BITS  = ((MW_BITS > scf_pkg::HEIGHT_BITS) ? MW_BITS
                                                                : scf_pkg::HEIGHT_BITS) + 1;
   localparam int ROW_BITS  = scf_pkg::ROW_BITS;
   localparam int TRIO_BITS = 3 * SAMPLE_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_PROD,
      ST_EMIT
   } st_type;

   logic [scf_pkg::WIDTH_BITS-1:0]          frame_width_ff;
   logic [scf_pkg::HEIGHT_BITS-1:0]         frame_height_ff;
   logic signed [scf_pkg::WEIGHT_BITS-1:0]  weight_middle_ff;
   logic signed [scf_pkg::WEIGHT_BITS-1:0]  weight_side_ff;
   logic signed [scf_pkg::WEIGHT_BITS-1:0]  weight_corner_ff;
   logic [scf_pkg::RECIP_BITS-1:0]          norm_recip_ff;

   st_type                 st_ff;
   logic [COL_BITS-1:0]    col_pos_ff;
   logic [ROW_BITS-1:0]    row_pos_ff;
   logic [COL_BITS-1:0]    col_ff;
   logic [TRIO_BITS-1:0]   sample_ff;
   logic                   produce_ff;
   logic                   last_ff;

   logic [DIM_BITS-1:0]    w_cfg, h_cfg, eff_w, eff_h;
   logic [COL_BITS-1:0]    col_now, col_in;
   logic [ROW_BITS-1:0]    row_now, row_in;
   logic [DIM_BITS-1:0]    col_inc, row_inc;
   logic                   wrap_col, wrap_row;
   logic                   produce_in, last_in;
   logic                   req_accept;

   logic [2*TRIO_BITS-1:0] line_mem [MAX_WIDTH];
   logic [2*TRIO_BITS-1:0] rd_data_ff;

   scf_pkg::lane_ctrl_type ctrl;
   scf_pkg::lane_coef_type coef;
   logic signed [SAMPLE_BITS-1:0] lane_result [3];
   logic                   merge_free;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= scf_pkg::RST_FRAME_WIDTH;
         frame_height_ff  <= scf_pkg::RST_FRAME_HEIGHT;
         weight_middle_ff <= scf_pkg::RST_WEIGHT_MIDDLE;
         weight_side_ff   <= scf_pkg::RST_WEIGHT_SIDE;
         weight_corner_ff <= scf_pkg::RST_WEIGHT_CORNER;
         norm_recip_ff    <= scf_pkg::RST_NORM_RECIP;
      end else if (csr_valid) begin
         unique case (scf_pkg::reg_index_type'(csr_index))
            scf_pkg::REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_wdata[scf_pkg::WIDTH_BITS-1:0];
            end
            scf_pkg::REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata[scf_pkg::HEIGHT_BITS-1:0];
            end
            scf_pkg::REG_WEIGHT_MIDDLE: begin
               weight_middle_ff <= $signed(csr_wdata[scf_pkg::WEIGHT_BITS-1:0]);
            end
            scf_pkg::REG_WEIGHT_SIDE: begin
               weight_side_ff <= $signed(csr_wdata[scf_pkg::WEIGHT_BITS-1:0]);
            end
            scf_pkg::REG_WEIGHT_CORNER: begin
               weight_corner_ff <= $signed(csr_wdata[scf_pkg::WEIGHT_BITS-1:0]);
            end
            scf_pkg::REG_NORM_RECIP: begin
               norm_recip_ff <= csr_wdata[scf_pkg::RECIP_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign coef.middle = weight_middle_ff;
   assign coef.side   = weight_side_ff;
   assign coef.corner = weight_corner_ff;
   assign coef.recip  = norm_recip_ff;

   always_comb begin
      w_cfg = DIM_BITS'(frame_width_ff);
      h_cfg = DIM_BITS'(frame_height_ff);
      priority if (w_cfg < DIM_BITS'(scf_pkg::MIN_DIM)) begin
         eff_w = DIM_BITS'(scf_pkg::MIN_DIM);
      end else if (w_cfg > DIM_BITS'(MAX_WIDTH)) begin
         eff_w = DIM_BITS'(MAX_WIDTH);
      end else begin
         eff_w = w_cfg;
      end
      priority if (h_cfg < DIM_BITS'(scf_pkg::MIN_DIM)) begin
         eff_h = DIM_BITS'(scf_pkg::MIN_DIM);
      end else if (h_cfg > DIM_BITS'(scf_pkg::MAX_HEIGHT)) begin
         eff_h = DIM_BITS'(scf_pkg::MAX_HEIGHT);
      end else begin
         eff_h = h_cfg;
      end

      col_now  = req_first_of_frame ? '0 : col_pos_ff;
      row_now  = req_first_of_frame ? '0 : row_pos_ff;
      col_inc  = DIM_BITS'(col_now) + DIM_BITS'(1);
      row_inc  = DIM_BITS'(row_now) + DIM_BITS'(1);
      wrap_col = col_inc >= eff_w;
      wrap_row = row_inc >= eff_h;
      col_in   = wrap_col ? '0 : col_inc[COL_BITS-1:0];
      if (!wrap_col) begin
         row_in = row_now;
      end else if (wrap_row) begin
         row_in = '0;
      end else begin
         row_in = row_inc[ROW_BITS-1:0];
      end
      produce_in = (row_now >= ROW_BITS'(2)) && (col_now >= COL_BITS'(2));
      last_in    = (DIM_BITS'(row_now) == eff_h - DIM_BITS'(1))
                && (DIM_BITS'(col_now) == eff_w - DIM_BITS'(1));
   end

   assign req_ready  = (st_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_IDLE;
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         produce_ff <= 1'b0;
      end else begin
         unique case (st_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  col_ff     <= col_now;
                  sample_ff  <= {req_sample_z, req_sample_y, req_sample_x};
                  produce_ff <= produce_in;
                  last_ff    <= last_in;
                  col_pos_ff <= col_in;
                  row_pos_ff <= row_in;
                  st_ff      <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               st_ff <= produce_ff ? ST_MUL : ST_IDLE;
            end
            ST_MUL: begin
               st_ff <= ST_PROD;
            end
            ST_PROD: begin
               st_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (merge_free) begin
                  st_ff <= ST_IDLE;
               end
            end
            default: begin
               st_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Each word holds the two previous rows of one column: older row above, newer row below.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= line_mem[col_now];
      end
      if (st_ff == ST_LOAD) begin
         line_mem[col_ff] <= {rd_data_ff[TRIO_BITS-1:0], sample_ff};
      end
   end

   assign ctrl.shift = (st_ff == ST_LOAD);
   assign ctrl.mul   = (st_ff == ST_MUL);
   assign ctrl.prod  = (st_ff == ST_PROD);

   for (genvar g = 0; g < 3; g++) begin : g_lane
      scf_lane #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .coef   (coef),
         .up2    ($signed(rd_data_ff[TRIO_BITS + g*SAMPLE_BITS +: SAMPLE_BITS])),
         .up1    ($signed(rd_data_ff[g*SAMPLE_BITS +: SAMPLE_BITS])),
         .sample ($signed(sample_ff[g*SAMPLE_BITS +: SAMPLE_BITS])),
         .result (lane_result[g])
      );
   end

   scf_merge #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_merge (
      .clock             (clock),
      .reset             (reset),
      .load              ((st_ff == ST_EMIT) && merge_free),
      .lane_x            (lane_result[0]),
      .lane_y            (lane_result[1]),
      .lane_z            (lane_result[2]),
      .last              (last_ff),
      .free              (merge_free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_filtered_x    (rsp_filtered_x),
      .rsp_filtered_y    (rsp_filtered_y),
      .rsp_filtered_z    (rsp_filtered_z),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

`ifndef NO_ASSERTIONS
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> st_ff == ST_LOAD)
      else $error("accepted request did not start a line store access");

   a_first_point: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_first_of_frame |=> col_pos_ff == COL_BITS'(1) && row_pos_ff == '0)
      else $error("raster position wrong after first point of frame");

   a_mul_needs_window: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_MUL |-> $past(st_ff) == ST_LOAD && produce_ff)
      else $error("arithmetic started for a point without a full window");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_EMIT && merge_free |=> rsp_valid)
      else $error("finished result did not reach the output register");
`endif

endmodule

`default_nettype wire

### test/stencil3x3_current_filter_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for stencil3x3_current_filter_top: directed, geometry, back-pressure
// and random raster tests against a built-in 3x3 stencil predictor.
// Depends on scf_pkg and the stencil3x3_current_filter_top RTL.

module stencil3x3_current_filter_top_test;

   localparam int SAMPLE_BITS   = 24;
   localparam int LINE_DEPTH    = 1024;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES    = 20;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int RANDOM_POINTS = 120;

   localparam logic [scf_pkg::CSR_INDEX_BITS-1:0] UNMAPPED_INDEX = 3'd7;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   localparam sample_type SAMPLE_MAX = 24'sh7FFFFF;
   localparam sample_type SAMPLE_MIN = 24'sh800000;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] fx;
      logic signed [SAMPLE_BITS-1:0] fy;
      logic signed [SAMPLE_BITS-1:0] fz;
      logic                          last_flag;
   } filtered_point_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid;
   logic                                req_ready;
   logic                                req_first_of_frame;
   sample_type                          req_sample_x;
   sample_type                          req_sample_y;
   sample_type                          req_sample_z;
   logic                                rsp_valid;
   logic                                rsp_ready;
   sample_type                          rsp_filtered_x;
   sample_type                          rsp_filtered_y;
   sample_type                          rsp_filtered_z;
   logic                                rsp_last_of_frame;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [scf_pkg::CSR_INDEX_BITS-1:0]  csr_index;
   logic [scf_pkg::CSR_DATA_BITS-1:0]   csr_wdata;

   stencil3x3_current_filter_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_first_of_frame (req_first_of_frame),
      .req_sample_x       (req_sample_x),
      .req_sample_y       (req_sample_y),
      .req_sample_z       (req_sample_z),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_x     (rsp_filtered_x),
      .rsp_filtered_y     (rsp_filtered_y),
      .rsp_filtered_z     (rsp_filtered_z),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   int                                     cfg_width  = int'(scf_pkg::RST_FRAME_WIDTH);
   int                                     cfg_height = int'(scf_pkg::RST_FRAME_HEIGHT);
   logic signed [scf_pkg::WEIGHT_BITS-1:0] cfg_middle = scf_pkg::RST_WEIGHT_MIDDLE;
   logic signed [scf_pkg::WEIGHT_BITS-1:0] cfg_side   = scf_pkg::RST_WEIGHT_SIDE;
   logic signed [scf_pkg::WEIGHT_BITS-1:0] cfg_corner = scf_pkg::RST_WEIGHT_CORNER;
   logic [scf_pkg::RECIP_BITS-1:0]         cfg_recip  = scf_pkg::RST_NORM_RECIP;

   longint line_store[2][LINE_DEPTH][3];
   longint window_cell[3][3][3];
   int     raster_col = 0;
   int     raster_row = 0;

   filtered_point_type expected_points[$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int req_gap_max    = 9;
   int rsp_stall_max  = 9;
   int rsp_hold_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int active_width();
      if (cfg_width < scf_pkg::MIN_DIM) return scf_pkg::MIN_DIM;
      if (cfg_width > LINE_DEPTH) return LINE_DEPTH;
      return cfg_width;
   endfunction

   function automatic int active_height();
      if (cfg_height < scf_pkg::MIN_DIM) return scf_pkg::MIN_DIM;
      if (cfg_height > scf_pkg::MAX_HEIGHT) return scf_pkg::MAX_HEIGHT;
      return cfg_height;
   endfunction

   function automatic sample_type filter_component(input int comp);
      longint mid;
      longint sides;
      longint corners;
      longint acc;
      longint scaled;
      mid = window_cell[1][1][comp];
      sides = window_cell[0][1][comp] + window_cell[1][0][comp]
            + window_cell[1][2][comp] + window_cell[2][1][comp];
      corners = window_cell[0][0][comp] + window_cell[0][2][comp]
              + window_cell[2][0][comp] + window_cell[2][2][comp];
      acc = longint'(cfg_middle) * mid + longint'(cfg_side) * sides
          + longint'(cfg_corner) * corners;
      scaled = (acc * longint'(cfg_recip)) >>> scf_pkg::FRAC_BITS;
      if (scaled > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
      if (scaled < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
      return sample_type'(scaled);
   endfunction

   function automatic void filter_point(input logic first, input sample_type sx,
                                        input sample_type sy, input sample_type sz);
      longint             comp_in[3];
      int                 w;
      int                 h;
      int                 col;
      int                 row;
      filtered_point_type result;
      w = active_width();
      h = active_height();
      if (first) begin
         raster_col = 0;
         raster_row = 0;
      end
      col = raster_col;
      row = raster_row;
      comp_in[0] = sx;
      comp_in[1] = sy;
      comp_in[2] = sz;
      for (int r = 0; r < 3; r++) begin
         window_cell[r][0] = window_cell[r][1];
         window_cell[r][1] = window_cell[r][2];
      end
      for (int c = 0; c < 3; c++) begin
         window_cell[0][2][c] = line_store[1][col][c];
         window_cell[1][2][c] = line_store[0][col][c];
         window_cell[2][2][c] = comp_in[c];
         line_store[1][col][c] = line_store[0][col][c];
         line_store[0][col][c] = comp_in[c];
      end
      if (row >= 2 && col >= 2) begin
         result.fx = filter_component(0);
         result.fy = filter_component(1);
         result.fz = filter_component(2);
         result.last_flag = (row == h - 1) && (col == w - 1);
         expected_points.push_back(result);
      end
      if (col + 1 >= w) begin
         raster_col = 0;
         raster_row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
         raster_col = col + 1;
      end
   endfunction

   function automatic sample_type random_sample();
      case ($urandom_range(15, 0))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2, 3: return sample_type'(int'($urandom_range(64, 0)) - 32);
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic send_point(input logic first, input sample_type sx, input sample_type sy,
                             input sample_type sz);
      int gap;
      gap = (req_gap_max == 0) ? 0 : $urandom_range(req_gap_max, 0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_first_of_frame <= first;
      req_sample_x <= sx;
      req_sample_y <= sy;
      req_sample_z <= sz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      filter_point(first, sx, sy, sz);
   endtask

   task automatic send_frame(input int points, input bit restart);
      for (int i = 0; i < points; i++) begin
         send_point(restart && i == 0, random_sample(), random_sample(), random_sample());
      end
   endtask

   task automatic wait_drained(input int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_points.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(input logic [scf_pkg::CSR_INDEX_BITS-1:0] reg_index,
                                 input logic [scf_pkg::CSR_DATA_BITS-1:0] data);
      wait_drained(SETTLE_CYCLES);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (reg_index)
         scf_pkg::REG_FRAME_WIDTH:   cfg_width = int'(data[scf_pkg::WIDTH_BITS-1:0]);
         scf_pkg::REG_FRAME_HEIGHT:  cfg_height = int'(data[scf_pkg::HEIGHT_BITS-1:0]);
         scf_pkg::REG_WEIGHT_MIDDLE: cfg_middle = data[scf_pkg::WEIGHT_BITS-1:0];
         scf_pkg::REG_WEIGHT_SIDE:   cfg_side = data[scf_pkg::WEIGHT_BITS-1:0];
         scf_pkg::REG_WEIGHT_CORNER: cfg_corner = data[scf_pkg::WEIGHT_BITS-1:0];
         scf_pkg::REG_NORM_RECIP:    cfg_recip = data[scf_pkg::RECIP_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic write_default_coefficients();
      write_register(scf_pkg::REG_WEIGHT_MIDDLE, {8'h00, scf_pkg::RST_WEIGHT_MIDDLE});
      write_register(scf_pkg::REG_WEIGHT_SIDE, {8'h00, scf_pkg::RST_WEIGHT_SIDE});
      write_register(scf_pkg::REG_WEIGHT_CORNER, {8'h00, scf_pkg::RST_WEIGHT_CORNER});
      write_register(scf_pkg::REG_NORM_RECIP, scf_pkg::RST_NORM_RECIP);
   endtask

   // Saturation in both directions, floor rounding of negative products, a restart part-way
   // through a frame and a write to an unmapped index.
   task automatic test_directed();
      write_register(scf_pkg::REG_FRAME_WIDTH, 16'd3);
      write_register(scf_pkg::REG_FRAME_HEIGHT, 16'd3);
      write_register(scf_pkg::REG_WEIGHT_MIDDLE, 16'd127);
      write_register(scf_pkg::REG_WEIGHT_SIDE, 16'hFF80);
      write_register(scf_pkg::REG_WEIGHT_CORNER, 16'd127);
      write_register(scf_pkg::REG_NORM_RECIP, 16'hFFFF);
      write_register(UNMAPPED_INDEX, 16'hFFFF);
      for (int i = 0; i < 9; i++) begin
         send_point(i == 0, SAMPLE_MAX, SAMPLE_MIN, (i == 4) ? -24'sd1 : 24'sd0);
      end
      write_default_coefficients();
      send_frame(4, 1'b1);
      for (int i = 0; i < 9; i++) begin
         send_point(i == 0, (i == 4) ? -24'sd1 : 24'sd0, (i == 4) ? 24'sd1 : 24'sd0,
                    (i == 4) ? 24'sd3 : 24'sd1);
      end
   endtask

   // Frame sizes beyond both ends of their ranges, sent without idling on either side.
   task automatic test_geometry_extremes();
      wait_drained(SETTLE_CYCLES);
      req_gap_max = 0;
      rsp_stall_max = 0;
      write_register(scf_pkg::REG_FRAME_WIDTH, 16'h07FF);
      write_register(scf_pkg::REG_FRAME_HEIGHT, 16'h0000);
      send_frame(32, 1'b1);
      write_register(scf_pkg::REG_FRAME_WIDTH, 16'h0000);
      write_register(scf_pkg::REG_FRAME_HEIGHT, 16'h1FFF);
      send_frame(scf_pkg::MIN_DIM * 16, 1'b1);
      write_register(scf_pkg::REG_FRAME_WIDTH, 16'd2);
      write_register(scf_pkg::REG_FRAME_HEIGHT, 16'd2);
      send_frame(2 * scf_pkg::MIN_DIM * scf_pkg::MIN_DIM, 1'b1);
      wait_drained(SETTLE_CYCLES);
      req_gap_max = 9;
      rsp_stall_max = 9;
   endtask

   // Width and height changed while the raster position is part-way through a frame.
   task automatic test_geometry_midframe();
      write_register(scf_pkg::REG_FRAME_WIDTH, 16'd10);
      write_register(scf_pkg::REG_FRAME_HEIGHT, 16'd6);
      send_frame(25, 1'b1);
      write_register(scf_pkg::REG_FRAME_WIDTH, 16'd4);
      send_frame(20, 1'b0);
      write_register(scf_pkg::REG_FRAME_WIDTH, 16'd14);
      send_frame(30, 1'b0);
      write_register(scf_pkg::REG_FRAME_HEIGHT, 16'd4);
      send_frame(40, 1'b0);
   endtask

   // The receiver holds off long enough for the block to stall its input; the sender then
   // pauses until every outstanding result has been delivered.
   task automatic test_backpressure();
      write_register(scf_pkg::REG_FRAME_WIDTH, 16'd8);
      write_register(scf_pkg::REG_FRAME_HEIGHT, 16'd8);
      req_gap_max = 0;
      rsp_stall_max = 0;
      rsp_hold_cycles = 200;
      send_frame(64, 1'b1);
      wait_drained(0);
      req_gap_max = 9;
      rsp_stall_max = 9;
      send_frame(64, 1'b1);
   endtask

   task automatic test_random_frames();
      int sent;
      int w;
      int h;
      int points;
      logic first;
      sent = 0;
      while (sent < RANDOM_POINTS) begin
         w = $urandom_range(12, scf_pkg::MIN_DIM);
         h = $urandom_range(8, scf_pkg::MIN_DIM);
         write_register(scf_pkg::REG_FRAME_WIDTH, {5'($urandom), 11'(w)});
         write_register(scf_pkg::REG_FRAME_HEIGHT, {3'($urandom), 13'(h)});
         if ($urandom_range(2, 0) == 0) begin
            write_default_coefficients();
         end else begin
            write_register(scf_pkg::REG_WEIGHT_MIDDLE, 16'($urandom));
            write_register(scf_pkg::REG_WEIGHT_SIDE, 16'($urandom));
            write_register(scf_pkg::REG_WEIGHT_CORNER, 16'($urandom));
            case ($urandom_range(5, 0))
               0: write_register(scf_pkg::REG_NORM_RECIP, 16'h0000);
               1: write_register(scf_pkg::REG_NORM_RECIP, 16'hFFFF);
               2: write_register(scf_pkg::REG_NORM_RECIP, scf_pkg::RST_NORM_RECIP);
               default: write_register(scf_pkg::REG_NORM_RECIP, 16'($urandom));
            endcase
         end
         req_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 9;
         rsp_stall_max = ($urandom_range(3, 0) == 0) ? 0 : 9;
         repeat ($urandom_range(2, 1)) begin
            points = w * h;
            if ($urandom_range(7, 0) == 0) points = $urandom_range(points, 1);
            for (int i = 0; i < points; i++) begin
               first = (i == 0) || ($urandom_range(40, 0) == 0);
               send_point(first, random_sample(), random_sample(), random_sample());
               sent++;
            end
         end
      end
      req_gap_max = 9;
      rsp_stall_max = 9;
   endtask

   initial begin
      int stall;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = (rsp_stall_max == 0) ? 0 : $urandom_range(rsp_stall_max, 0);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      filtered_point_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            mismatch_count++;
            $display("%0t: expected no result, got x=%0d y=%0d z=%0d last=%0b",
                     $time, rsp_filtered_x, rsp_filtered_y, rsp_filtered_z,
                     rsp_last_of_frame);
         end else begin
            want = expected_points.pop_front();
            if (rsp_filtered_x !== want.fx) begin
               mismatch_count++;
               $display("%0t: filtered_x expected %0d, got %0d",
                        $time, want.fx, rsp_filtered_x);
            end
            if (rsp_filtered_y !== want.fy) begin
               mismatch_count++;
               $display("%0t: filtered_y expected %0d, got %0d",
                        $time, want.fy, rsp_filtered_y);
            end
            if (rsp_filtered_z !== want.fz) begin
               mismatch_count++;
               $display("%0t: filtered_z expected %0d, got %0d",
                        $time, want.fz, rsp_filtered_z);
            end
            if (rsp_last_of_frame !== want.last_flag) begin
               mismatch_count++;
               $display("%0t: last_of_frame expected %0b, got %0b",
                        $time, want.last_flag, rsp_last_of_frame);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("stencil3x3_current_filter_top: mismatch");
         $finish;
      end
   end

   initial begin
      req_valid <= 1'b0;
      req_first_of_frame <= 1'b0;
      req_sample_x <= '0;
      req_sample_y <= '0;
      req_sample_z <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_geometry_extremes();
      test_geometry_midframe();
      test_backpressure();
      test_random_frames();
      wait_drained(END_CYCLES);
      if (mismatch_count == 0) begin
         $display("stencil3x3_current_filter_top: match");
      end else begin
         $display("stencil3x3_current_filter_top: mismatch");
      end
      $finish;
   end

endmodule
